@@ hdl/psbc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path safety byte checker package
// Shared types and constants for the checker, its classifier and its configuration channel.
// ----------------------------------------------------------------------------
package psbc_pkg;

  // Configuration channel layout.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 21;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOWS_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH   = 2'd1;

  // Length limit after reset: one mebibyte.
  localparam logic [CFG_DATA_W-1:0] MAX_LENGTH_RESET = 21'd1048576;

  // Code for the terminating byte of a string.
  localparam logic [7:0] BYTE_END = 8'h00;

  // Bound on the first continuation byte of a multi-byte sequence.
  typedef enum logic [2:0] {
    RULE_NONE   = 3'd0,
    RULE_MIN_A0 = 3'd1,
    RULE_MAX_9F = 3'd2,
    RULE_MIN_90 = 3'd3,
    RULE_MAX_8F = 3'd4
  } cont_rule_t;

  // Kind of the previous byte, for the dot-dot and slash-slash checks.
  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_DOT   = 2'd1,
    KIND_SLASH = 2'd2
  } byte_kind_t;

  // Everything the string state needs to know about one byte.
  typedef struct packed {
    logic       bad_char;     // forbidden punctuation or control byte
    logic       is_backslash; // allowed only in Windows mode
    byte_kind_t kind;
    logic       is_ascii;     // 0x00 .. 0x7F
    logic       is_cont;      // 10xx_xxxx
    logic       ge_a0;
    logic       ge_90;
    logic       lead_bad;     // non-ASCII byte that cannot start a sequence
    logic [1:0] lead_len;     // continuation bytes that follow a valid lead
    cont_rule_t lead_rule;
  } byte_class_t;

endpackage

@@ hdl/psbc_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path byte channel
// Valid/ready channel that carries one path byte per beat.
// ----------------------------------------------------------------------------
interface psbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;

  modport source (output valid, output byte_req, input ready);
  modport sink   (input valid, input byte_req, output ready);
endinterface

@@ hdl/psbc_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Verdict channel
// Valid/ready channel that carries one string verdict per beat.
// ----------------------------------------------------------------------------
interface psbc_out_if;
  logic valid;
  logic ready;
  logic safe;

  modport source (output valid, output safe, input ready);
  modport sink   (input valid, input safe, output ready);
endinterface

@@ hdl/psbc_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that carries a register index and write data per beat.
// ----------------------------------------------------------------------------
interface psbc_cfg_if
  import psbc_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/psbc_byte_class.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte classifier
// Decodes one path byte into character and UTF-8 lead/continuation classes.
// ----------------------------------------------------------------------------
module psbc_byte_class
  import psbc_pkg::*;
(
  input  logic [7:0]  byte_in,
  output byte_class_t cls
);

  always_comb begin
    cls = '0;

    // Forbidden shell punctuation; backslash is flagged apart.
    case (byte_in)
      8'h3B, 8'h7C, 8'h26, 8'h3C, 8'h3E, 8'h60,
      8'h24, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h21: cls.bad_char = 1'b1;
      default: cls.bad_char = 1'b0;
    endcase
    cls.is_backslash = (byte_in == 8'h5C);

    // Control bytes other than tab, LF and CR; 0x80 and above never count.
    if ((byte_in < 8'h20 || byte_in == 8'h7F) &&
        byte_in != 8'h09 && byte_in != 8'h0A && byte_in != 8'h0D) begin
      cls.bad_char = 1'b1;
    end

    if (byte_in == 8'h2E) begin
      cls.kind = KIND_DOT;
    end else if (byte_in == 8'h2F) begin
      cls.kind = KIND_SLASH;
    end else begin
      cls.kind = KIND_OTHER;
    end

    // UTF-8 classes.
    cls.is_ascii = ~byte_in[7];
    cls.is_cont  = (byte_in[7:6] == 2'b10);
    cls.ge_a0    = (byte_in >= 8'hA0);
    cls.ge_90    = (byte_in >= 8'h90);

    cls.lead_rule = RULE_NONE;
    cls.lead_len  = 2'd0;
    if (byte_in >= 8'hC2 && byte_in <= 8'hDF) begin
      cls.lead_len = 2'd1;
    end else if (byte_in[7:4] == 4'hE) begin
      cls.lead_len = 2'd2;
      if (byte_in == 8'hE0) begin
        cls.lead_rule = RULE_MIN_A0;
      end else if (byte_in == 8'hED) begin
        cls.lead_rule = RULE_MAX_9F;
      end
    end else if (byte_in >= 8'hF0 && byte_in <= 8'hF4) begin
      cls.lead_len = 2'd3;
      if (byte_in == 8'hF0) begin
        cls.lead_rule = RULE_MIN_90;
      end else if (byte_in == 8'hF4) begin
        cls.lead_rule = RULE_MAX_8F;
      end
    end
    // Stray continuations, 0xC0, 0xC1 and 0xF5 and up cannot start a sequence.
    cls.lead_bad = byte_in[7] && (cls.lead_len == 2'd0);
  end

endmodule

@@ hdl/path_safety_byte_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path safety byte checker
// Streams a zero-terminated path one byte per beat and gives one verdict
// per string.
// ----------------------------------------------------------------------------
// The block takes one path byte per clock and returns one verdict beat for
// each zero byte: safe is 1 when the string was strict UTF-8, held no
// forbidden punctuation or control byte, no "..", no "//" and no backslash outside Windows
// mode, and was not longer than max_length. Each byte passes an input
// register and then the classifier and string state update into the verdict
// register, which holds the verdict until it is taken; bytes are taken every
// cycle, limited only by the verdict register when the result side stalls.
// Configuration writes are taken at any time and are meant for idle periods.
module path_safety_byte_checker
  import psbc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 21
) (
  input  logic       clk,
  input  logic       rst_n,
  psbc_in_if.sink    in_ch,
  psbc_out_if.source out_ch,
  psbc_cfg_if.sink   cfg_ch
);

  localparam int unsigned CMP_W =
    (COUNT_WIDTH > CFG_DATA_W) ? COUNT_WIDTH : CFG_DATA_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Configuration registers.
  logic                  windows_mode_r;
  logic [CFG_DATA_W-1:0] max_length_r;

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // String state.
  logic [1:0]             cont_left_r, cont_left_nxt;
  cont_rule_t             rule_r, rule_nxt;
  byte_kind_t             prev_kind_r, prev_kind_nxt;
  logic                   failed_r, failed_nxt;
  logic [COUNT_WIDTH-1:0] byte_count_r, byte_count_nxt;

  // Verdict register.
  logic out_valid_r, out_valid_nxt;
  logic safe_r, safe_nxt;

  byte_class_t cls;
  logic        s1_end;
  logic        out_free;
  logic        s1_fire;
  logic        end_fire;
  logic        cont_ok;

  // Configuration writes.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      windows_mode_r <= 1'b0;
      max_length_r   <= MAX_LENGTH_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_WINDOWS_MODE: windows_mode_r <= cfg_ch.data[0];
        REG_MAX_LENGTH:   max_length_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Handshake: the input register drains unless an end byte meets a full
  // verdict register that is not being taken.
  assign s1_end   = (s1_byte_r == BYTE_END);
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_fire  = s1_valid_r && (!s1_end || out_free);
  assign end_fire = s1_fire && s1_end;
  assign in_ch.ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.byte_req;
    end
  end

  psbc_byte_class u_class (
    .byte_in (s1_byte_r),
    .cls     (cls)
  );

  // Bound check on a continuation byte.
  always_comb begin
    case (rule_r)
      RULE_MIN_A0: cont_ok = cls.is_cont && cls.ge_a0;
      RULE_MAX_9F: cont_ok = cls.is_cont && !cls.ge_a0;
      RULE_MIN_90: cont_ok = cls.is_cont && cls.ge_90;
      RULE_MAX_8F: cont_ok = cls.is_cont && !cls.ge_90;
      default:     cont_ok = cls.is_cont;
    endcase
  end

  // String state update for one byte.
  always_comb begin
    cont_left_nxt  = cont_left_r;
    rule_nxt       = rule_r;
    prev_kind_nxt  = prev_kind_r;
    failed_nxt     = failed_r;
    byte_count_nxt = byte_count_r;
    safe_nxt       = safe_r;

    if (s1_fire) begin
      if (s1_end) begin
        safe_nxt = !failed_r && (cont_left_r == 2'd0) &&
                   (CMP_W'(byte_count_r) <= CMP_W'(max_length_r));
        cont_left_nxt  = 2'd0;
        rule_nxt       = RULE_NONE;
        prev_kind_nxt  = KIND_OTHER;
        failed_nxt     = 1'b0;
        byte_count_nxt = '0;
      end else begin
        // Saturating length count.
        if (byte_count_r == COUNT_MAX) begin
          failed_nxt = 1'b1;
        end else begin
          byte_count_nxt = byte_count_r + 1'b1;
        end

        // UTF-8 sequence tracking.
        if (cont_left_r != 2'd0) begin
          rule_nxt = RULE_NONE;
          if (cont_ok) begin
            cont_left_nxt = cont_left_r - 2'd1;
          end else begin
            failed_nxt    = 1'b1;
            cont_left_nxt = 2'd0;
          end
        end else if (!cls.is_ascii) begin
          if (cls.lead_bad) begin
            failed_nxt = 1'b1;
          end else begin
            cont_left_nxt = cls.lead_len;
            rule_nxt      = cls.lead_rule;
          end
        end

        // Character checks.
        if (cls.bad_char || (cls.is_backslash && !windows_mode_r)) begin
          failed_nxt = 1'b1;
        end
        if (cls.kind == KIND_DOT && prev_kind_r == KIND_DOT) begin
          failed_nxt = 1'b1;
        end
        if (cls.kind == KIND_SLASH && prev_kind_r == KIND_SLASH && !windows_mode_r) begin
          failed_nxt = 1'b1;
        end
        prev_kind_nxt = cls.kind;
      end
    end
  end

  // Verdict beat is held until taken.
  always_comb begin
    if (end_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cont_left_r  <= 2'd0;
      rule_r       <= RULE_NONE;
      prev_kind_r  <= KIND_OTHER;
      failed_r     <= 1'b0;
      byte_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      cont_left_r  <= cont_left_nxt;
      rule_r       <= rule_nxt;
      prev_kind_r  <= prev_kind_nxt;
      failed_r     <= failed_nxt;
      byte_count_r <= byte_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    safe_r <= safe_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.safe  = safe_r;

  // A continuation bound is only pending while continuations are expected.
  a_rule_needs_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (rule_r != RULE_NONE) |-> (cont_left_r != 2'd0))
    else $error("continuation rule set with no continuation pending");

  // An end byte clears the string state.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    end_fire |=> (byte_count_r == '0 && !failed_r && cont_left_r == 2'd0))
    else $error("string state not cleared after end byte");

  // A verdict appears only after an end byte was consumed.
  a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(end_fire))
    else $error("verdict raised without an end byte");

  // A byte past the saturated count fails the string.
  a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !s1_end && byte_count_r == COUNT_MAX) |=> failed_r)
    else $error("count overflow did not fail the string");

endmodule
